[src/assert_macros.svh]
// assertion helpers for the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked on every edge, reset included
`define BFA_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
// checked outside reset
`define BFA_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define BFA_ASSERT(lbl, clk, prop, msg)
`define BFA_ASSERT_RST(lbl, clk, rst, prop, msg)
`endif
`endif

[src/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// types and codes shared by the best-fit allocator modules
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  localparam logic [15:0] ARENA_RESET = 16'd4096;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_size;
    logic [15:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_offset;
    logic [15:0] granted_size;
  } rsp_t;

  // one row of the block table
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] payload;
    logic        used;
  } entry_t;

  typedef struct packed {
    logic init;
    logic accept;
    logic shift_start;
    logic wr1;
    logic wr2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic fail;
    logic need_shift;
    logic two_writes;
    logic shift_busy;
    logic out_free;
  } sts_t;

endpackage

[src/bfa_ram.sv]
// ----------------------------------------------------------------------------
// bfa_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bfa_ctrl.sv]
// ----------------------------------------------------------------------------
// bfa_ctrl
// sequencer: init, scan, decide, shift, write back, respond
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_WR1    = 3'd5;
  localparam logic [2:0] S_WR2    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.fail) begin
          state_next = S_DONE;
        end else if (sts.need_shift) begin
          cmd.shift_start = 1'b1;
          state_next      = S_SHIFT;
        end else begin
          state_next = S_WR1;
        end
      end
      S_SHIFT: begin
        if (!sts.shift_busy) begin
          state_next = S_WR1;
        end
      end
      S_WR1: begin
        cmd.wr1    = 1'b1;
        state_next = sts.two_writes ? S_WR2 : S_DONE;
      end
      S_WR2: begin
        cmd.wr2    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
    // an arena write rebuilds the table
    if (cfg_we) begin
      state_next = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

endmodule

[src/bfa_datapath.sv]
// ----------------------------------------------------------------------------
// bfa_datapath
// block table ram, scan pipeline, shift engine and result register
// ----------------------------------------------------------------------------
module bfa_datapath import bfa_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  req_t        req_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp_data
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = $bits(entry_t);
  localparam logic [15:0] HDR = 16'(HEADER_BYTES);

  logic [15:0]   arena;
  logic [CW-1:0] count;
  logic          op;
  logic [15:0]   req_sz;
  logic [15:0]   off;

  // scan pipeline
  logic          sc_issue;
  logic [IW-1:0] rd_ptr;
  logic          ev_vld;
  logic [IW-1:0] ev_idx;

  // best (alloc) or matching (free) entry and its neighbours
  logic          found;
  logic [IW-1:0] bidx;
  logic [15:0]   bs, bp;
  logic          bu;
  logic [15:0]   ps, pp;
  logic          pu;
  logic [15:0]   np;
  logic          nu;
  logic          next_got;

  // payload granted by the write-back, held for the response
  logic [15:0]   grant_sz;

  // shift engine
  logic          sh_issue;
  logic          sh_up;
  logic [IW-1:0] sh_src;
  logic [IW-1:0] sh_last;
  logic [1:0]    sh_k;
  logic          wr_vld;
  logic [IW-1:0] wr_addr;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  entry_t        q;

  assign q = entry_t'(ram_rdata);

  // plan, valid once the scan has finished
  logic          is_alloc;
  logic          split;
  logic          bad;
  logic          mn, mp;
  logic [CW-1:0] d_c, k_c;
  logic [15:0]   merged;
  logic [15:0]   init_pl;
  entry_t        w1_e, w2_e;
  logic [IW-1:0] w1_a;

  always_comb begin
    is_alloc = (op == OP_ALLOC);
    split    = ({1'b0, bp} > ({1'b0, req_sz} + {1'b0, HDR})) &&
               (count < CW'(MAX_BLOCKS));
    bad      = !found || !bu;
    mn       = next_got && !nu;
    mp       = (bidx != '0) && !pu;
    d_c      = mp ? CW'(bidx) : CW'(bidx) + CW'(1);
    k_c      = (mp && mn) ? CW'(2) : CW'(1);
    merged   = mn ? (bp + HDR + np) : bp;
    init_pl  = (arena > HDR) ? (arena - HDR) : 16'd0;
    if (is_alloc) begin
      w1_a = bidx;
      w1_e = '{start: bs, payload: (split ? req_sz : bp), used: 1'b1};
    end else if (mp) begin
      w1_a = bidx - IW'(1);
      w1_e = '{start: ps, payload: (pp + HDR + merged), used: 1'b0};
    end else begin
      w1_a = bidx;
      w1_e = '{start: bs, payload: merged, used: 1'b0};
    end
    w2_e = '{start: (bs + HDR + req_sz), payload: (bp - HDR - req_sz), used: 1'b0};
  end

  always_comb begin
    sts.scan_done  = ev_vld && ((CW'(ev_idx) + CW'(1)) == count);
    sts.fail       = is_alloc ? !found : bad;
    sts.need_shift = is_alloc ? (split && ((CW'(bidx) + CW'(1)) < count))
                              : ((mp || mn) && ((d_c + k_c) < count));
    sts.two_writes = is_alloc && split;
    sts.shift_busy = sh_issue || wr_vld;
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

  // ram port selection
  always_comb begin
    ram_raddr = sc_issue ? rd_ptr : sh_src;
    ram_we    = wr_vld || cmd.init || cmd.wr1 || cmd.wr2;
    if (wr_vld) begin
      ram_waddr = wr_addr;
      ram_wdata = ram_rdata;
    end else if (cmd.init) begin
      ram_waddr = '0;
      ram_wdata = EW'(entry_t'{start: 16'd0, payload: init_pl, used: 1'b0});
    end else if (cmd.wr2) begin
      ram_waddr = bidx + IW'(1);
      ram_wdata = EW'(w2_e);
    end else begin
      ram_waddr = w1_a;
      ram_wdata = EW'(w1_e);
    end
  end

  bfa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arena <= ARENA_RESET;
    end else if (cfg_we) begin
      arena <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
    end else if (cmd.init) begin
      count <= CW'(1);
    end else if (cmd.wr1) begin
      if (is_alloc && split) begin
        count <= count + CW'(1);
      end else if (!is_alloc && (mp || mn)) begin
        count <= count - k_c;
      end
    end
  end

  // split decision depends on count, so capture the grant before count moves
  always_ff @(posedge clk) begin
    if (cmd.wr1) begin
      grant_sz <= split ? req_sz : bp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op     <= req_data.opcode;
      req_sz <= req_data.request_size;
      off    <= req_data.block_offset;
    end
  end

  // scan address side
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_issue <= 1'b0;
      ev_vld   <= 1'b0;
    end else begin
      ev_vld <= sc_issue;
      if (cmd.accept) begin
        sc_issue <= 1'b1;
      end else if (sc_issue && ((CW'(rd_ptr) + CW'(1)) == count)) begin
        sc_issue <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx <= rd_ptr;
    if (cmd.accept) begin
      rd_ptr <= '0;
    end else if (sc_issue) begin
      rd_ptr <= rd_ptr + IW'(1);
    end
  end

  // scan evaluation side
  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      next_got <= 1'b0;
    end else if (cmd.accept) begin
      found    <= 1'b0;
      next_got <= 1'b0;
    end else if (ev_vld) begin
      if (op == OP_ALLOC) begin
        if (!q.used && (q.payload >= req_sz) && (!found || (q.payload < bp))) begin
          found <= 1'b1;
          bidx  <= ev_idx;
          bs    <= q.start;
          bp    <= q.payload;
          bu    <= q.used;
        end
      end else begin
        if (!found && (q.start == off)) begin
          found <= 1'b1;
          bidx  <= ev_idx;
          bs    <= q.start;
          bp    <= q.payload;
          bu    <= q.used;
        end else if (!found) begin
          ps <= q.start;
          pp <= q.payload;
          pu <= q.used;
        end else if (!next_got) begin
          next_got <= 1'b1;
          np       <= q.payload;
          nu       <= q.used;
        end
      end
    end
  end

  // shift engine: read one entry, write it in the next cycle at its new place
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_issue <= 1'b0;
      wr_vld   <= 1'b0;
    end else begin
      wr_vld <= sh_issue;
      if (cmd.shift_start) begin
        sh_issue <= 1'b1;
      end else if (sh_issue && (sh_src == sh_last)) begin
        sh_issue <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= sh_up ? (sh_src + IW'(1)) : (sh_src - IW'(sh_k));
    if (cmd.shift_start) begin
      if (is_alloc) begin
        sh_up   <= 1'b1;
        sh_src  <= IW'(count - CW'(1));
        sh_last <= bidx + IW'(1);
      end else begin
        sh_up   <= 1'b0;
        sh_src  <= IW'(d_c + k_c);
        sh_last <= IW'(count - CW'(1));
      end
      sh_k <= 2'(k_c);
    end else if (sh_issue && (sh_src != sh_last)) begin
      sh_src <= sh_up ? (sh_src - IW'(1)) : (sh_src + IW'(1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (is_alloc) begin
        rsp_data.status         <= found ? ST_OK : ST_NO_FIT;
        rsp_data.granted_offset <= found ? bs : 16'd0;
        rsp_data.granted_size   <= found ? grant_sz : 16'd0;
      end else begin
        rsp_data.status         <= bad ? ST_BAD : ST_OK;
        rsp_data.granted_offset <= 16'd0;
        rsp_data.granted_size   <= 16'd0;
      end
    end
  end

endmodule

[src/best_fit_allocator_top.sv]
// sequence: block table scan, decide, an optional shift of table entries, write-back in
//   state WR1 and, for a split, also WR2, then the result register
// throughput: one request at a time, paced by the single read port walk of the block ram;
//   the next beat is taken the cycle after the result is loaded
// reset: synchronous; the init state writes the single free block, also after arena writes
// ----------------------------------------------------------------------------
// best_fit_allocator_top
// best-fit block allocator with split and coalescing over a byte arena
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module best_fit_allocator_top import bfa_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  // arena size register
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  // request beat
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_data,
  // response beat
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp_data
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer owns the request side handshake
  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table ram, scan and shift engines, response register
  bfa_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // an accepted beat makes the block busy on the next cycle
  `BFA_ASSERT_RST(a_busy_after_accept, clk, rst, (req_valid && !req_stall && !cfg_we) |=> req_stall, "accept did not leave idle")
  // a result is only loaded into a free response slot
  `BFA_ASSERT_RST(a_load_free_slot, clk, rst, cmd.out_load |-> (!rsp_valid || !rsp_stall), "response overwritten")
  // a failed request never moves table entries
  `BFA_ASSERT_RST(a_no_shift_on_fail, clk, rst, cmd.shift_start |-> !sts.fail, "shift on failed request")
  // no request is taken while a response is being loaded
  `BFA_ASSERT(a_load_not_accept, clk, !(cmd.out_load && cmd.accept), "load and accept overlap")

endmodule
